// ===== src/lupe_pkg.sv =====
`default_nettype none

package lupe_pkg;

    localparam int MAX_UNIT_CHANNELS  = 510;
    localparam int MAX_CHUNK          = 255;
    localparam int FRAME_CHANNELS_MAX = 65536;
    localparam int SHORT_COUNT        = 30;
    localparam int MAX_START_PIXEL    = MAX_UNIT_CHANNELS / 3;
    localparam int MAX_UNIT_ADDRESS   = 240;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;
    localparam int POS_W       = 17;
    localparam int SKIP_W      = 9;
    localparam int REM_W       = 10;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_INDEX_W-1:0] REG_UNIT_ADDRESS   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_PIXEL    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_COUNT    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_OFFSET   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_CHANNELS = 3'd4;

    localparam logic [7:0] BYTE_SYNC       = 8'h00;
    localparam logic [7:0] BYTE_PACKET_CMD = 8'h8E;
    localparam logic [7:0] BYTE_SKIP_LONG  = 8'h3F;
    localparam logic [7:0] BYTE_SKIP_SHORT = 8'h20;
    localparam logic [7:0] BYTE_DATA_LONG  = 8'h1F;

    // one command per accepted beat that produces bytes
    typedef struct packed {
        logic              hdr;
        logic [7:0]        unit_address;
        logic [SKIP_W-1:0] skips;
        logic              trail_empty;
        logic              chunk_hdr;
        logic [7:0]        chunk_len;
        logic              data;
        logic [7:0]        value;
        logic              last;
    } cmd_t;

    // back end working copy of a command, flags cleared as bytes go out
    typedef struct packed {
        logic              h0;
        logic              h1;
        logic              h2;
        logic [7:0]        unit_address;
        logic [SKIP_W-1:0] skip_left;
        logic              skip_len_pend;
        logic [7:0]        skip_len;
        logic              trail_empty;
        logic              chunk_hdr;
        logic              chunk_len_pend;
        logic [7:0]        chunk_len;
        logic              data;
        logic [7:0]        value;
        logic              last;
    } work_t;

endpackage

`default_nettype wire

// ===== src/lupe_in_if.sv =====
`default_nettype none

interface lupe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] channel_value;
    logic       frame_start;

    modport source (output valid, output channel_value, output frame_start, input ready);
    modport sink (input valid, input channel_value, input frame_start, output ready);
endinterface

`default_nettype wire

// ===== src/lupe_out_if.sv =====
`default_nettype none

interface lupe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       packet_end;

    modport source (output valid, output out_byte, output packet_end, input ready);
    modport sink (input valid, input out_byte, input packet_end, output ready);
endinterface

`default_nettype wire

// ===== src/lupe_cfg_if.sv =====
`default_nettype none

interface lupe_cfg_if
    import lupe_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/lupe_front.sv =====
`default_nettype none

module lupe_front
    import lupe_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    lupe_in_if.sink     frame,
    lupe_cfg_if.sink    cfg,
    input  wire         q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    logic [7:0]            unit_address_reg;
    logic [7:0]            start_pixel_reg;
    logic [7:0]            pixel_count_reg;
    logic [CFG_DATA_W-1:0] frame_offset_reg;
    logic [CFG_DATA_W-1:0] frame_channels_reg;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [7:0]       chunk_reg, chunk_next;
    logic             active_reg, active_next;

    logic [9:0]            s3, n3;
    logic [10:0]           used3;
    logic [CFG_DATA_W-1:0] fc_clamped;
    logic                  cfg_ok;
    logic [9:0]            skips_full;
    logic                  accept;
    logic [POS_W-1:0]      pos_eff;
    logic [REM_W-1:0]      rem_eff;
    logic [7:0]            chunk_eff;
    logic                  active_eff;
    logic                  match;
    logic [7:0]            c;

    assign cfg.ready   = 1'b1;
    assign frame.ready = !q_full;
    assign accept      = frame.valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_address_reg   <= 8'd1;
            start_pixel_reg    <= 8'd0;
            pixel_count_reg    <= 8'd0;
            frame_offset_reg   <= CFG_DATA_W'(1);
            frame_channels_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_UNIT_ADDRESS:   unit_address_reg   <= cfg.data[7:0];
                REG_START_PIXEL:    start_pixel_reg    <= cfg.data[7:0];
                REG_PIXEL_COUNT:    pixel_count_reg    <= cfg.data[7:0];
                REG_FRAME_OFFSET:   frame_offset_reg   <= cfg.data;
                REG_FRAME_CHANNELS: frame_channels_reg <= cfg.data;
                default:            ;
            endcase
        end
    end

    // range checks, with used + 3 kept unsigned
    always_comb
    begin
        s3    = {2'b00, start_pixel_reg} + {1'b0, start_pixel_reg, 1'b0};
        n3    = {2'b00, pixel_count_reg} + {1'b0, pixel_count_reg, 1'b0};
        used3 = {1'b0, s3} + {1'b0, n3};
        fc_clamped = (frame_channels_reg > CFG_DATA_W'(FRAME_CHANNELS_MAX))
                   ? CFG_DATA_W'(FRAME_CHANNELS_MAX) : frame_channels_reg;
        cfg_ok = (start_pixel_reg <= 8'(MAX_START_PIXEL))
              && (used3 <= 11'(MAX_UNIT_CHANNELS + 3))
              && (frame_offset_reg != '0)
              && (({7'b0, used3} + {1'b0, frame_offset_reg})
                  <= ({1'b0, fc_clamped} + 18'd4))
              && (unit_address_reg != 8'd0)
              && (unit_address_reg <= 8'(MAX_UNIT_ADDRESS));
        skips_full = (start_pixel_reg != 8'd0) ? (s3 - 10'd3) : 10'd0;
    end

    always_comb
    begin
        q_cmd       = '0;
        q_cmd.value = frame.channel_value;
        pos_eff     = pos_reg;
        rem_eff     = rem_reg;
        chunk_eff   = chunk_reg;
        active_eff  = active_reg;
        c           = 8'd0;

        if (frame.frame_start)
        begin
            pos_eff    = '0;
            rem_eff    = '0;
            chunk_eff  = 8'd0;
            active_eff = 1'b0;
            if (cfg_ok)
            begin
                q_cmd.hdr          = 1'b1;
                q_cmd.unit_address = unit_address_reg;
                q_cmd.skips        = skips_full[SKIP_W-1:0];
                rem_eff            = n3;
                if (n3 == '0)
                    q_cmd.trail_empty = 1'b1;
                else
                    active_eff = 1'b1;
            end
        end

        match = active_eff && (rem_eff != '0) && (frame_offset_reg != '0)
             && (({1'b0, pos_eff} + 18'd1) >= {1'b0, frame_offset_reg});

        rem_next    = rem_eff;
        chunk_next  = chunk_eff;
        active_next = active_eff;
        if (match)
        begin
            if (chunk_eff == 8'd0)
            begin
                c = (rem_eff > REM_W'(MAX_CHUNK)) ? 8'(MAX_CHUNK) : rem_eff[7:0];
                q_cmd.chunk_hdr = 1'b1;
                q_cmd.chunk_len = c;
                chunk_next      = c - 8'd1;
            end
            else
            begin
                chunk_next = chunk_eff - 8'd1;
            end
            q_cmd.data = 1'b1;
            rem_next   = rem_eff - REM_W'(1);
            if (rem_eff == REM_W'(1))
            begin
                q_cmd.last  = 1'b1;
                active_next = 1'b0;
                chunk_next  = 8'd0;
            end
        end

        pos_next = (pos_eff != '1) ? (pos_eff + POS_W'(1)) : pos_eff;
        q_push   = accept && (q_cmd.hdr || q_cmd.data);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            rem_reg    <= '0;
            chunk_reg  <= '0;
            active_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            rem_reg    <= rem_next;
            chunk_reg  <= chunk_next;
            active_reg <= active_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/lupe_queue.sv =====
`default_nettype none

module lupe_queue
    import lupe_pkg::*;
(
    input  wire   clk,
    input  wire   rst_n,
    input  wire   push,
    input  cmd_t  push_cmd,
    output logic  full,
    input  wire   pop,
    output cmd_t  head_cmd,
    output logic  empty
);

    cmd_t              slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push, do_pop;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = slots[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (QPTR_W+1)'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - (QPTR_W+1)'(1);
        end
    end

endmodule

`default_nettype wire

// ===== src/lupe_back.sv =====
`default_nettype none

module lupe_back
    import lupe_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        q_empty,
    input  cmd_t       q_head,
    output logic       q_pop,
    lupe_out_if.source packet
);

    work_t      work_reg, work_next;
    work_t      stepped, after;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_end_reg;
    logic       load_out;
    logic       emit;
    logic [7:0] byte_sel;
    logic       end_sel;
    logic [7:0] j;

    function automatic logic busy(input work_t w);
        busy = w.h0 || w.h1 || w.h2 || w.skip_len_pend || (w.skip_left != '0)
            || w.trail_empty || w.chunk_hdr || w.chunk_len_pend || w.data || w.last;
    endfunction

    function automatic work_t from_cmd(input cmd_t c);
        work_t w;
        w                = '0;
        w.h0             = c.hdr;
        w.h1             = c.hdr;
        w.h2             = c.hdr;
        w.unit_address   = c.unit_address;
        w.skip_left      = c.skips;
        w.trail_empty    = c.trail_empty;
        w.chunk_hdr      = c.chunk_hdr;
        w.chunk_len      = c.chunk_len;
        w.data           = c.data;
        w.value          = c.value;
        w.last           = c.last;
        from_cmd = w;
    endfunction

    assign load_out = !out_valid_reg || packet.ready;
    assign emit     = busy(work_reg) && load_out;

    always_comb
    begin
        stepped  = work_reg;
        byte_sel = BYTE_SYNC;
        end_sel  = 1'b0;
        j        = (work_reg.skip_left > SKIP_W'(MAX_CHUNK))
                 ? 8'(MAX_CHUNK) : work_reg.skip_left[7:0];

        if (work_reg.h0)
        begin
            stepped.h0 = 1'b0;
        end
        else if (work_reg.h1)
        begin
            byte_sel   = work_reg.unit_address;
            stepped.h1 = 1'b0;
        end
        else if (work_reg.h2)
        begin
            byte_sel   = BYTE_PACKET_CMD;
            stepped.h2 = 1'b0;
        end
        else if (work_reg.skip_len_pend)
        begin
            byte_sel              = work_reg.skip_len;
            stepped.skip_len_pend = 1'b0;
        end
        else if (work_reg.skip_left != '0)
        begin
            stepped.skip_left = work_reg.skip_left - {1'b0, j};
            if (j > 8'(SHORT_COUNT))
            begin
                byte_sel              = BYTE_SKIP_LONG;
                stepped.skip_len_pend = 1'b1;
                stepped.skip_len      = j;
            end
            else
            begin
                byte_sel = BYTE_SKIP_SHORT | j;
            end
        end
        else if (work_reg.trail_empty)
        begin
            end_sel             = 1'b1;
            stepped.trail_empty = 1'b0;
        end
        else if (work_reg.chunk_hdr)
        begin
            stepped.chunk_hdr = 1'b0;
            if (work_reg.chunk_len > 8'(SHORT_COUNT))
            begin
                byte_sel               = BYTE_DATA_LONG;
                stepped.chunk_len_pend = 1'b1;
            end
            else
            begin
                byte_sel = work_reg.chunk_len;
            end
        end
        else if (work_reg.chunk_len_pend)
        begin
            byte_sel               = work_reg.chunk_len;
            stepped.chunk_len_pend = 1'b0;
        end
        else if (work_reg.data)
        begin
            byte_sel     = (work_reg.value == 8'd0) ? 8'd1 : work_reg.value;
            stepped.data = 1'b0;
        end
        else
        begin
            end_sel      = 1'b1;
            stepped.last = 1'b0;
        end

        after     = emit ? stepped : work_reg;
        q_pop     = !busy(after) && !q_empty;
        work_next = q_pop ? from_cmd(q_head) : after;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            work_reg <= work_next;
            if (load_out)
                out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= byte_sel;
            out_end_reg  <= end_sel;
        end
    end

    assign packet.valid      = out_valid_reg;
    assign packet.out_byte   = out_byte_reg;
    assign packet.packet_end = out_end_reg;

endmodule

`default_nettype wire

// ===== src/lighting_unit_packet_encoder.sv =====
// lighting unit packet encoder
// frame: one channel byte per beat, frame_start set on the first byte of a frame
// packet: one packet byte per beat, packet_end set on the trailing zero
// cfg: register writes (index, data), always ready; write only while idle
// at frame start the registers are range checked; a failing frame yields nothing
// a passing frame yields sync, unit id, packet command and skip commands at once,
// then each of the unit's channel bytes, with a chunk count where a chunk opens,
// and a trailing zero after the last channel
// the front end takes one frame beat per cycle into a four-entry queue while not full;
// the back end sends one packet byte per cycle from its output register unless stalled
// a beat's bytes pass through a queue slot, the work register and the output register
// sustained rate: one frame beat per cycle when it yields no bytes and the queue is not
// full; otherwise the front end keeps pace with the packet bytes: one per channel beat
// inside a chunk and up to three where a chunk opens or the packet ends
// header bursts of up to ten bytes are absorbed by the queue
// a stalled receiver holds the output register; the queue fills, then frame.ready drops
// reset restores register defaults and empties the queue and output register
`default_nettype none

module lighting_unit_packet_encoder
    import lupe_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    lupe_in_if.sink    frame,
    lupe_cfg_if.sink   cfg,
    lupe_out_if.source packet
);

    logic q_push, q_full, q_pop, q_empty;
    cmd_t q_cmd, q_head;

    lupe_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame),
        .cfg    (cfg),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (q_cmd)
    );

    lupe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head_cmd (q_head),
        .empty    (q_empty)
    );

    lupe_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .packet  (packet)
    );

endmodule

`default_nettype wire

// ===== verif/lighting_unit_packet_encoder_tb.sv =====
module lighting_unit_packet_encoder_tb
    import lupe_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 100;
    localparam int IDLE_PCT       = 11;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SKIP_CHUNK     = 255;
    localparam int POS_LIMIT      = 'h1FFFF;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_end;
    } pkt_byte_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic steady;
    int   fail_count = 0;
    int   quiet_cycles = 0;

    lupe_in_if  frame_bus ();
    lupe_cfg_if cfg_bus ();
    lupe_out_if packet_bus ();

    lighting_unit_packet_encoder DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_bus),
        .cfg    (cfg_bus),
        .packet (packet_bus)
    );

    // encoder model state
    logic [7:0]  unit_id;
    logic [7:0]  first_pixel;
    logic [7:0]  pixel_total;
    logic [16:0] chan_offset;
    logic [16:0] frame_size;
    int          frame_pos;
    int          chans_left;
    int          chunk_left;
    bit          active;

    pkt_byte_t packet_bytes_due[$];
    pkt_byte_t due;

    always #1 clk = ~clk;

    always @(negedge clk)
    begin
        packet_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && packet_bus.valid && packet_bus.ready)
        begin
            if (packet_bytes_due.size() == 0)
            begin
                $error("packet byte 8'h%02h with no byte due", packet_bus.out_byte);
                fail_count++;
            end
            else
            begin
                due = packet_bytes_due.pop_front();
                if (packet_bus.out_byte !== due.out_byte)
                begin
                    $error("out_byte: expected 8'h%02h, actual 8'h%02h",
                           due.out_byte, packet_bus.out_byte);
                    fail_count++;
                end
                if (packet_bus.packet_end !== due.packet_end)
                begin
                    $error("packet_end: expected %0b, actual %0b",
                           due.packet_end, packet_bus.packet_end);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((frame_bus.valid && frame_bus.ready) || (packet_bus.valid && packet_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("lighting_unit_packet_encoder regression: fail");
            $finish;
        end
    end

    function automatic void push_byte(input logic [7:0] b, input logic is_end);
        pkt_byte_t entry;
        entry.out_byte = b;
        entry.packet_end = is_end;
        packet_bytes_due = {packet_bytes_due, entry};
    endfunction

    function automatic void encode_beat(input logic [7:0] level, input logic starts_frame);
        int  s;
        int  used;
        int  limit;
        int  skips;
        int  step;
        bit  fits;
        s = int'(first_pixel);
        used = (s - 1) * 3 + int'(pixel_total) * 3;
        limit = (frame_size > FRAME_CHANNELS_MAX) ? FRAME_CHANNELS_MAX : int'(frame_size);
        fits = (s * 3 <= MAX_UNIT_CHANNELS) && (used <= MAX_UNIT_CHANNELS)
            && (chan_offset != 0) && (used + int'(chan_offset) - 1 <= limit)
            && (unit_id >= 1) && (unit_id <= MAX_UNIT_ADDRESS);
        if (starts_frame)
        begin
            frame_pos = 0;
            active = 0;
            chans_left = 0;
            chunk_left = 0;
            if (fits)
            begin
                push_byte(BYTE_SYNC, 1'b0);
                push_byte(unit_id, 1'b0);
                push_byte(BYTE_PACKET_CMD, 1'b0);
                skips = (s - 1) * 3;
                while (skips > 0)
                begin
                    step = (skips < SKIP_CHUNK) ? skips : SKIP_CHUNK;
                    skips -= step;
                    if (step > SHORT_COUNT)
                    begin
                        push_byte(BYTE_SKIP_LONG, 1'b0);
                        push_byte(8'(step), 1'b0);
                    end
                    else
                        push_byte(BYTE_SKIP_SHORT | 8'(step), 1'b0);
                end
                chans_left = int'(pixel_total) * 3;
                if (chans_left == 0)
                    push_byte(BYTE_SYNC, 1'b1);
                else
                    active = 1;
            end
        end
        if (active && chans_left > 0 && chan_offset != 0
            && frame_pos >= int'(chan_offset) - 1)
        begin
            if (chunk_left == 0)
            begin
                chunk_left = (chans_left < MAX_CHUNK) ? chans_left : MAX_CHUNK;
                if (chunk_left > SHORT_COUNT)
                    push_byte(BYTE_DATA_LONG, 1'b0);
                push_byte(8'(chunk_left), 1'b0);
            end
            push_byte((level == 8'h00) ? 8'h01 : level, 1'b0);
            chunk_left--;
            chans_left--;
            if (chans_left == 0)
            begin
                push_byte(BYTE_SYNC, 1'b1);
                active = 0;
                chunk_left = 0;
            end
        end
        if (frame_pos < POS_LIMIT)
            frame_pos++;
    endfunction

    function automatic logic [7:0] random_level();
        return ($urandom_range(99) < 15) ? 8'h00 : 8'($urandom());
    endfunction

    task automatic send_beat(input logic [7:0] level, input logic starts_frame);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            frame_bus.valid <= 1'b0;
            @(negedge clk);
        end
        frame_bus.valid <= 1'b1;
        frame_bus.channel_value <= level;
        frame_bus.frame_start <= starts_frame;
        do @(posedge clk); while (frame_bus.ready !== 1'b1);
        encode_beat(level, starts_frame);
        @(negedge clk);
    endtask

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++)
            send_beat(random_level(), i == 0);
    endtask

    // wait for every due byte, then let in-flight beats settle
    task automatic drain();
        frame_bus.valid <= 1'b0;
        while (packet_bytes_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= value;
        do @(posedge clk); while (cfg_bus.ready !== 1'b1);
        case (idx)
            REG_UNIT_ADDRESS:   unit_id = value[7:0];
            REG_START_PIXEL:    first_pixel = value[7:0];
            REG_PIXEL_COUNT:    pixel_total = value[7:0];
            REG_FRAME_OFFSET:   chan_offset = value;
            REG_FRAME_CHANNELS: frame_size = value;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_unit(input logic [7:0] addr, input logic [7:0] sp,
                            input logic [7:0] pc, input logic [16:0] fo,
                            input logic [16:0] fc);
        drain();
        write_reg(REG_UNIT_ADDRESS, 17'(addr));
        write_reg(REG_START_PIXEL, 17'(sp));
        write_reg(REG_PIXEL_COUNT, 17'(pc));
        write_reg(REG_FRAME_OFFSET, fo);
        write_reg(REG_FRAME_CHANNELS, fc);
        cfg_bus.valid <= 1'b0;
    endtask

    // beats before any frame start, then a frame with register defaults
    task automatic test_reset_defaults();
        send_beat(8'h55, 1'b0);
        send_beat(random_level(), 1'b1);
        send_beat(8'hAA, 1'b0);
    endtask

    task automatic test_channel_values();
        logic [7:0] levels[6] = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'h00};
        set_unit(8'd240, 8'd1, 8'd2, 17'd1, 17'd6);
        foreach (levels[i])
            send_beat(levels[i], i == 0);
        send_beat(8'h00, 1'b0);
    endtask

    task automatic test_skip_commands();
        logic [7:0] starts[5] = '{8'd11, 8'd12, 8'd86, 8'd87, 8'd170};
        foreach (starts[i])
        begin
            set_unit(8'd7, starts[i], 8'd0, 17'd1, 17'd65536);
            send_beat(random_level(), 1'b1);
        end
    endtask

    task automatic test_range_checks();
        set_unit(8'd0, 8'd1, 8'd1, 17'd1, 17'd3);
        send_frame(4);
        set_unit(8'd241, 8'd1, 8'd1, 17'd1, 17'd3);
        send_frame(2);
        set_unit(8'd255, 8'd1, 8'd1, 17'd1, 17'd3);
        send_frame(2);
        set_unit(8'd5, 8'd171, 8'd0, 17'd1, 17'd65536);
        send_frame(1);
        set_unit(8'd5, 8'd1, 8'd255, 17'd1, 17'd65536);
        send_frame(1);
        set_unit(8'd5, 8'd1, 8'd1, 17'd0, 17'd65536);
        send_frame(2);
        set_unit(8'd5, 8'd1, 8'd1, 17'd2, 17'd3);
        send_frame(4);
        set_unit(8'd5, 8'd1, 8'd1, 17'd2, 17'd4);
        send_frame(4);
        // frame size above the maximum is clamped
        set_unit(8'd5, 8'd0, 8'd0, 17'd65540, 17'h1FFFF);
        send_frame(1);
        set_unit(8'd5, 8'd0, 8'd0, 17'd65541, 17'h1FFFF);
        send_frame(1);
        set_unit(8'd1, 8'd255, 8'd255, 17'h1FFFF, 17'd0);
        send_frame(1);
    endtask

    // a new frame start abandons the packet without a trailer
    task automatic test_short_frame();
        set_unit(8'd9, 8'd1, 8'd2, 17'd1, 17'd6);
        send_frame(3);
        send_frame(7);
    endtask

    // start pixel zero with a long chunk, no idling on either side
    task automatic test_full_unit();
        steady = 1'b1;
        set_unit(8'd240, 8'd0, 8'd20, 17'd1, 17'd57);
        send_frame(62);
        drain();
        steady = 1'b0;
    endtask

    task automatic test_random_frames();
        int          sent;
        int          len;
        int          need;
        int          used;
        logic [7:0]  addr;
        logic [7:0]  sp;
        logic [7:0]  pc;
        logic [16:0] fo;
        logic [16:0] fc;
        sent = 0;
        addr = 8'd1;
        sp = 8'd0;
        pc = 8'd0;
        fo = 17'd1;
        fc = 17'd0;
        while (sent < RANDOM_ITEMS)
        begin
            // now and then keep the settings so a frame start lands on a busy block
            if (sent == 0 || $urandom_range(99) >= 30)
            begin
                addr = ($urandom_range(99) < 90) ? 8'($urandom_range(1, MAX_UNIT_ADDRESS))
                                                 : 8'($urandom_range(241, 256));
                sp = ($urandom_range(99) < 90) ? 8'($urandom_range(0, 20)) : 8'($urandom());
                pc = ($urandom_range(99) < 90) ? 8'($urandom_range(0, 14))
                                               : 8'($urandom_range(0, 40));
                fo = ($urandom_range(99) < 95) ? 17'($urandom_range(1, 6)) : 17'($urandom());
                used = (int'(sp) - 1) * 3 + int'(pc) * 3 + int'(fo) - 1;
                if (used < 0)
                    used = 0;
                case ($urandom_range(9))
                    0: fc = 17'($urandom());
                    1: fc = (used > 0) ? 17'(used - 1) : 17'd0;
                    default: fc = 17'(used + $urandom_range(0, 2));
                endcase
                set_unit(addr, sp, pc, fo, fc);
            end
            need = int'(fo) - 1 + int'(pc) * 3;
            len = need + $urandom_range(1, 3);
            if ($urandom_range(99) < 15)
                len = $urandom_range(1, need + 1);
            if (len > 80)
                len = 80;
            if (len > RANDOM_ITEMS - sent)
                len = RANDOM_ITEMS - sent;
            send_frame(len);
            sent += len;
        end
    endtask

    initial
    begin
        frame_bus.valid = 1'b0;
        frame_bus.channel_value = 8'h00;
        frame_bus.frame_start = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_UNIT_ADDRESS;
        cfg_bus.data = '0;
        packet_bus.ready = 1'b0;
        steady = 1'b0;
        unit_id = 8'd1;
        first_pixel = 8'd0;
        pixel_total = 8'd0;
        chan_offset = 17'd1;
        frame_size = 17'd0;
        frame_pos = 0;
        chans_left = 0;
        chunk_left = 0;
        active = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_channel_values();
        test_skip_commands();
        test_range_checks();
        test_short_frame();
        test_full_unit();
        test_random_frames();

        drain();
        if (fail_count == 0)
            $display("lighting_unit_packet_encoder regression: pass");
        else
            $display("lighting_unit_packet_encoder regression: fail");
        $finish;
    end

endmodule

// ===== lighting_unit_packet_encoder.f =====
src/lupe_pkg.sv
src/lupe_in_if.sv
src/lupe_out_if.sv
src/lupe_cfg_if.sv
src/lupe_front.sv
src/lupe_queue.sv
src/lupe_back.sv
src/lighting_unit_packet_encoder.sv
verif/lighting_unit_packet_encoder_tb.sv
